FILE: design/rrqs_pkg.sv
// Package for the round-robin quantum scheduler.
// Holds the command and result transaction types, status codes and defaults.
// No dependencies.
package rrqs_pkg;

	localparam int DEF_QUEUE_DEPTH = 16;
	localparam int DEF_CYCLE_WIDTH = 16;

	localparam int ID_W    = 4;
	localparam int FIELD_W = 16;
	localparam int TIME_W  = 32;

	localparam logic KIND_ENQUEUE  = 1'b0;
	localparam logic KIND_DISPATCH = 1'b1;

	typedef enum logic [2:0] {
		ST_ENQUEUED  = 3'd0,
		ST_REFUSED   = 3'd1,
		ST_REQUEUED  = 3'd2,
		ST_COMPLETED = 3'd3,
		ST_IDLE      = 3'd4
	} rrqs_status_t;

	typedef struct packed {
		logic               kind;
		logic [ID_W-1:0]    job_id;
		logic [FIELD_W-1:0] burst_cycles;
	} rrqs_cmd_t;

	typedef struct packed {
		rrqs_status_t       status;
		logic [ID_W-1:0]    ran_job;
		logic [FIELD_W-1:0] ran_cycles;
		logic [FIELD_W-1:0] left_cycles;
		logic [TIME_W-1:0]  elapsed_time;
	} rrqs_result_t;

	// Per-cell control from the queue controller.
	typedef struct packed {
		logic load;
		logic shift;
	} rrqs_cell_ctl_t;

endpackage

FILE: design/rrqs_cell.sv
// One slot of the shifting ready queue: holds a job id and its remaining cycles.
// Depends on rrqs_pkg for the cell control type.
module rrqs_cell import rrqs_pkg::*; #(
	parameter int DATA_W = ID_W + DEF_CYCLE_WIDTH
) (
	input  logic              clk,
	input  rrqs_cell_ctl_t    ctl,
	input  logic [DATA_W-1:0] new_data,
	input  logic [DATA_W-1:0] next_data,
	output logic [DATA_W-1:0] data
);

	logic [DATA_W-1:0] data_q;

	// A load wins over the shift so a requeued job lands in the freed tail slot.
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			data_q <= new_data;
		end else if (ctl.shift) begin
			data_q <= next_data;
		end
	end

	assign data = data_q;

endmodule

FILE: design/round_robin_quantum_scheduler_unit.sv
// Top level of the round-robin quantum scheduler: queue control, time counter, result register.
// Depends on rrqs_pkg and rrqs_cell.
//
//   port group        | dir | handshake                          | payload
//   ------------------+-----+------------------------------------+---------------
//   command           | in  | start & !busy accepts               | cmd (rrqs_cmd_t)
//   result            | out | done, one cycle, no back-pressure    | result (rrqs_result_t)
//   quantum register  | in  | cfg_we writes                       | cfg_data
//
// One command is taken every cycle; busy is always low. The result of a command
// appears with done in the cycle after it was accepted, set by the single
// register stage after the head cell and the min/subtract logic. The queue is a
// row of cells with the head in cell 0; a dispatch on a non-empty queue shifts
// every cell one place toward the head. Reset clears the count and time and sets
// the quantum to one; cells hold stale data.
module round_robin_quantum_scheduler_unit import rrqs_pkg::*; #(
	parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH,
	parameter int CYCLE_WIDTH = DEF_CYCLE_WIDTH
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  rrqs_cmd_t          cmd,
	output logic               done,
	output rrqs_result_t       result,
	input  logic               cfg_we,
	input  logic [FIELD_W-1:0] cfg_data
);

	localparam int LW     = (CYCLE_WIDTH < FIELD_W) ? CYCLE_WIDTH : FIELD_W;
	localparam int DATA_W = ID_W + LW;
	localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);

	logic [CNT_W-1:0]  count_q;
	logic [TIME_W-1:0] time_q;
	logic [LW-1:0]     quantum_q;
	logic              done_q;
	rrqs_result_t      result_q;

	logic [DATA_W-1:0] cell_data [QUEUE_DEPTH];
	rrqs_cell_ctl_t    cell_ctl  [QUEUE_DEPTH];

	logic              accept;
	logic              is_dispatch;
	logic              full;
	logic              empty;
	logic              do_push;
	logic              do_pop;
	logic              requeue;
	logic [ID_W-1:0]   head_id;
	logic [LW-1:0]     head_left;
	logic [LW-1:0]     ran;
	logic [LW-1:0]     left_after;
	logic [LW-1:0]     burst;
	logic [DATA_W-1:0] load_data;
	logic [CNT_W-1:0]  load_slot;
	logic [CNT_W-1:0]  count_d;
	rrqs_result_t      result_d;

	assign busy        = 1'b0;
	assign accept      = start && !busy;
	assign is_dispatch = (cmd.kind == KIND_DISPATCH);
	assign full        = (count_q == CNT_W'(QUEUE_DEPTH));
	assign empty       = (count_q == '0);
	assign burst       = cmd.burst_cycles[LW-1:0];

	assign head_id    = cell_data[0][DATA_W-1:LW];
	assign head_left  = cell_data[0][LW-1:0];
	assign ran        = (quantum_q < head_left) ? quantum_q : head_left;
	assign left_after = head_left - ran;

	assign do_push = accept && !is_dispatch && !full;
	assign do_pop  = accept && is_dispatch && !empty;
	assign requeue = do_pop && (left_after != '0);

	// After a pop every entry moves down one, so the requeue slot is count - 1.
	assign load_slot = is_dispatch ? (count_q - CNT_W'(1)) : count_q;
	assign load_data = is_dispatch ? {head_id, left_after} : {cmd.job_id, burst};

	for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
		logic [DATA_W-1:0] next_data;

		if (i == QUEUE_DEPTH - 1) begin : g_last
			assign next_data = cell_data[i];
		end else begin : g_mid
			assign next_data = cell_data[i+1];
		end

		assign cell_ctl[i].shift = do_pop;
		assign cell_ctl[i].load  = (do_push || requeue) && (load_slot == CNT_W'(i));

		rrqs_cell #(
			.DATA_W(DATA_W)
		) u_cell (
			.clk      (clk),
			.ctl      (cell_ctl[i]),
			.new_data (load_data),
			.next_data(next_data),
			.data     (cell_data[i])
		);
	end

	always_comb begin
		count_d  = count_q;
		result_d = '0;
		if (!is_dispatch) begin
			result_d.status      = full ? ST_REFUSED : ST_ENQUEUED;
			result_d.ran_job     = cmd.job_id;
			result_d.left_cycles = FIELD_W'(burst);
			result_d.elapsed_time = time_q;
			if (!full) begin
				count_d = count_q + CNT_W'(1);
			end
		end else if (empty) begin
			result_d.status       = ST_IDLE;
			result_d.elapsed_time = time_q;
		end else begin
			result_d.status       = (left_after != '0) ? ST_REQUEUED : ST_COMPLETED;
			result_d.ran_job      = head_id;
			result_d.ran_cycles   = FIELD_W'(ran);
			result_d.left_cycles  = FIELD_W'(left_after);
			result_d.elapsed_time = time_q + TIME_W'(ran);
			if (left_after == '0) begin
				count_d = count_q - CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= '0;
			time_q    <= '0;
			quantum_q <= LW'(1);
			done_q    <= 1'b0;
		end else begin
			done_q <= accept;
			if (cfg_we) begin
				quantum_q <= cfg_data[LW-1:0];
			end
			if (accept) begin
				count_q <= count_d;
				time_q  <= result_d.elapsed_time;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			result_q <= result_d;
		end
	end

	assign done   = done_q;
	assign result = result_q;

	// The fill count never passes the queue depth.
	assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(QUEUE_DEPTH))
		else $error("queue count exceeds depth");

	// Every accepted command yields exactly one result in the next cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> done)
		else $error("accepted command produced no result");

	// A dispatch on an empty queue leaves the count and time untouched.
	assert property (@(posedge clk) disable iff (!arst_n)
		(accept && is_dispatch && empty) |=> ($stable(count_q) && $stable(time_q)))
		else $error("idle dispatch changed queue state");

	// An idle result carries no job and no cycles.
	assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.status == ST_IDLE) |->
		(result.ran_job == '0 && result.ran_cycles == '0 && result.left_cycles == '0))
		else $error("idle result carries job data");

endmodule

FILE: bench/round_robin_quantum_scheduler_unit_test.sv
// Testbench for round_robin_quantum_scheduler_unit: directed and random command streams
// checked against a built-in scheduler model. Depends on rrqs_pkg and the design files.
`timescale 1ns / 100ps

module round_robin_quantum_scheduler_unit_test;
	import rrqs_pkg::*;

	localparam int QUEUE_DEPTH = DEF_QUEUE_DEPTH;
	localparam int QUIET_LIMIT = 500;
	localparam int PHASE_ITEMS = 190;

	typedef struct packed {
		logic [ID_W-1:0]    id;
		logic [FIELD_W-1:0] remaining;
	} ready_job_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               start = 1'b0;
	logic               busy;
	rrqs_cmd_t          cmd = '0;
	logic               done;
	rrqs_result_t       result;
	logic               cfg_we = 1'b0;
	logic [FIELD_W-1:0] cfg_data = '0;

	// Scheduler model state.
	logic [FIELD_W-1:0] model_quantum = 16'd1;
	ready_job_t         ready_jobs[$];
	logic [TIME_W-1:0]  model_elapsed = '0;

	rrqs_cmd_t    job_requests[$];
	rrqs_result_t expected_reports[$];
	int unsigned  requests_queued = 0;
	int unsigned  requests_taken = 0;
	int unsigned  quiet_cycles = 0;
	int unsigned  mismatches = 0;
	int unsigned  gap_max = 7;
	int unsigned  gap_left = 0;
	logic         cmd_taken = 1'b0;

	round_robin_quantum_scheduler_unit i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.busy     (busy),
		.cmd      (cmd),
		.done     (done),
		.result   (result),
		.cfg_we   (cfg_we),
		.cfg_data (cfg_data)
	);

	always #10 clk = ~clk;

	function automatic rrqs_result_t run_scheduler(rrqs_cmd_t c);
		rrqs_result_t r;
		ready_job_t head;
		logic [FIELD_W-1:0] slice;
		r = '0;
		if (c.kind == KIND_ENQUEUE) begin
			r.ran_job = c.job_id;
			r.left_cycles = c.burst_cycles;
			if (ready_jobs.size() >= QUEUE_DEPTH) begin
				r.status = ST_REFUSED;
			end else begin
				head.id = c.job_id;
				head.remaining = c.burst_cycles;
				ready_jobs = {ready_jobs, head};
				r.status = ST_ENQUEUED;
			end
		end else if (ready_jobs.size() == 0) begin
			r.status = ST_IDLE;
		end else begin
			head = ready_jobs.pop_front();
			slice = (model_quantum < head.remaining) ? model_quantum : head.remaining;
			head.remaining = head.remaining - slice;
			model_elapsed = model_elapsed + slice;
			r.ran_job = head.id;
			r.ran_cycles = slice;
			r.left_cycles = head.remaining;
			if (head.remaining != 0) begin
				ready_jobs = {ready_jobs, head};
				r.status = ST_REQUEUED;
			end else begin
				r.status = ST_COMPLETED;
			end
		end
		r.elapsed_time = model_elapsed;
		return r;
	endfunction

	task automatic check_report(rrqs_result_t exp_r, rrqs_result_t got);
		if (got.status !== exp_r.status) begin
			$error("status: expected %0d, got %0d", exp_r.status, got.status);
			mismatches++;
		end
		if (got.ran_job !== exp_r.ran_job) begin
			$error("ran_job: expected %0d, got %0d", exp_r.ran_job, got.ran_job);
			mismatches++;
		end
		if (got.ran_cycles !== exp_r.ran_cycles) begin
			$error("ran_cycles: expected %0d, got %0d", exp_r.ran_cycles, got.ran_cycles);
			mismatches++;
		end
		if (got.left_cycles !== exp_r.left_cycles) begin
			$error("left_cycles: expected %0d, got %0d", exp_r.left_cycles, got.left_cycles);
			mismatches++;
		end
		if (got.elapsed_time !== exp_r.elapsed_time) begin
			$error("elapsed_time: expected %0d, got %0d", exp_r.elapsed_time,
				got.elapsed_time);
			mismatches++;
		end
	endtask

	// Driver: holds each transaction until it is taken, then waits its drawn gap.
	always @(negedge clk) begin
		if (!arst_n) begin
			start <= 1'b0;
		end else if (start && !cmd_taken) begin
			// Still waiting for the block to take the current command.
		end else if (gap_left != 0) begin
			gap_left = gap_left - 1;
			start <= 1'b0;
		end else if (job_requests.size() != 0) begin
			cmd <= job_requests.pop_front();
			start <= 1'b1;
			gap_left = $urandom_range(0, gap_max);
		end else begin
			start <= 1'b0;
		end
	end

	// Monitor and model update; results are checked before a new command is predicted.
	always @(posedge clk) begin
		if (arst_n) begin
			if (done) begin
				if (expected_reports.size() == 0) begin
					$error("result transaction with no command outstanding");
					mismatches++;
				end else begin
					check_report(expected_reports.pop_front(), result);
				end
			end
			if (cfg_we)
				model_quantum = cfg_data;
			cmd_taken <= start && !busy;
			if (start && !busy) begin
				expected_reports = {expected_reports, run_scheduler(cmd)};
				requests_taken <= requests_taken + 1;
			end
			quiet_cycles <= ((start && !busy) || done) ? 0 : quiet_cycles + 1;
		end
	end

	initial begin
		while (quiet_cycles < QUIET_LIMIT)
			@(posedge clk);
		$display("*** FAILED ***");
		$finish;
	end

	task automatic queue_request(logic kind, logic [ID_W-1:0] id, logic [FIELD_W-1:0] burst);
		rrqs_cmd_t c;
		c.kind = kind;
		c.job_id = id;
		c.burst_cycles = burst;
		job_requests = {job_requests, c};
		requests_queued++;
	endtask

	task automatic wait_idle();
		while (requests_taken != requests_queued || expected_reports.size() != 0)
			@(negedge clk);
		repeat (3) @(negedge clk);
	endtask

	task automatic write_quantum(logic [FIELD_W-1:0] q);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_data <= q;
		@(negedge clk);
		cfg_we <= 1'b0;
		cfg_data <= FIELD_W'($urandom_range(0, 65535));
		@(negedge clk);
	endtask

	initial begin
		logic [FIELD_W-1:0] quanta[8];
		logic [FIELD_W-1:0] q;
		logic [FIELD_W-1:0] burst;
		int unsigned burst_top;
		int unsigned enq_pct;
		int unsigned batch;
		int unsigned phase_count;
		quanta = '{16'd0, 16'd65535, 16'd1, 16'd3, 16'd200, 16'd40000, 16'd9, 16'd1000};
		repeat (2) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed part, run with the quantum left at its reset value of one.
		gap_max = 0;
		queue_request(KIND_DISPATCH, 4'd9, 16'h1234);
		queue_request(KIND_ENQUEUE, 4'd0, 16'd0);
		queue_request(KIND_ENQUEUE, 4'd15, 16'hFFFF);
		queue_request(KIND_ENQUEUE, 4'd5, 16'd2);
		queue_request(KIND_DISPATCH, 4'd0, 16'd0);
		queue_request(KIND_DISPATCH, 4'd15, 16'hFFFF);
		queue_request(KIND_DISPATCH, 4'd3, 16'd7);
		// Two jobs remain, so fourteen more fill the queue and the next ones are refused.
		for (int i = 0; i < 14; i++)
			queue_request(KIND_ENQUEUE, i[ID_W-1:0], i[FIELD_W-1:0]);
		queue_request(KIND_ENQUEUE, 4'd10, 16'hAAAA);
		queue_request(KIND_ENQUEUE, 4'd5, 16'h5555);
		wait_idle();

		for (int p = 0; p < 8; p++) begin
			q = quanta[p];
			write_quantum(q);
			burst_top = (q == 0) ? 8 : ((q > 16000) ? 65535 : 4 * q);
			phase_count = 0;
			while (phase_count < PHASE_ITEMS) begin
				batch = $urandom_range(20, 60);
				enq_pct = 30 + 20 * $urandom_range(0, 2);
				gap_max = ($urandom_range(0, 2) == 0) ? 0 : 7;
				for (int n = 0; n < batch; n++) begin
					case ($urandom_range(0, 7))
						0: burst = '0;
						1: burst = FIELD_W'($urandom_range(0, 65535));
						2: burst = 16'hFFFF;
						default: burst = FIELD_W'($urandom_range(1, burst_top));
					endcase
					if ($urandom_range(0, 99) < enq_pct)
						queue_request(KIND_ENQUEUE, ID_W'($urandom_range(0, 15)), burst);
					else
						queue_request(KIND_DISPATCH, ID_W'($urandom_range(0, 15)), burst);
				end
				phase_count += batch;
				// The sender holds off here until every result of the batch is back.
				wait_idle();
			end
		end

		wait_idle();
		if (mismatches == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
